// File: design/bsr_pkg.sv
// Shared types and constants for the startup ramp sequencer.
package bsr_pkg;

  // Field widths
  localparam int unsigned ValW    = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned ProdW   = 2 * ValW;
  localparam int unsigned NumW    = ProdW + 1;
  localparam int unsigned BitCntW = $clog2(NumW);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_DEBOUNCE  = 3'd1,
    REG_START     = 3'd2,
    REG_END       = 3'd3,
    REG_RAMP      = 3'd4
  } reg_idx_t;

  // Top level sequencing
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_HOLD = 3'b100
  } seq_state_t;

  // Arithmetic unit sequencing
  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_MUL  = 4'b0010,
    U_ADD  = 4'b0100,
    U_DIV  = 4'b1000
  } unit_state_t;

  // Request to the ramp unit: step = ceil(span * cnt / divisor), clamped to span
  typedef struct packed {
    logic            start;
    logic [ValW-1:0] span;
    logic [ValW-1:0] cnt;
    logic [ValW-1:0] divisor;
  } ramp_req_t;

  typedef struct packed {
    logic            done;
    logic [ValW-1:0] step;
  } ramp_rsp_t;

endpackage

// File: design/bsr_if.sv
// Handshake channel interfaces: tick samples, results and register writes.
interface bsr_sample_if import bsr_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ValW-1:0] throttle;
  modport source (output valid, output throttle, input ready);
  modport sink   (input valid, input throttle, output ready);
endinterface

interface bsr_result_if import bsr_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            motor_on;
  logic            ramping;
  logic [ValW-1:0] interval;
  logic            interval_update;
  logic            start_event;
  logic            stop_event;
  modport source (output valid, output motor_on, output ramping, output interval,
                  output interval_update, output start_event, output stop_event,
                  input ready);
  modport sink   (input valid, input motor_on, input ramping, input interval,
                  input interval_update, input start_event, input stop_event,
                  output ready);
endinterface

interface bsr_cfg_if import bsr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [ValW-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/bsr_ramp_unit.sv
// Bit-serial shift-add multiplier followed by a restoring divider for the ramp step.
module bsr_ramp_unit import bsr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  ramp_req_t req,
  output ramp_rsp_t rsp
);

  unit_state_t        state;
  logic [BitCntW-1:0] bit_cnt;
  logic [NumW-1:0]    acc;
  logic [ProdW-1:0]   mcand;
  logic [ValW-1:0]    mplier;
  logic [ValW-1:0]    dvsr;
  logic [ValW-1:0]    spn;
  logic [ValW:0]      rem;
  logic               done;

  // one divide step: bring down the next numerator bit, try the subtract
  logic [ValW:0] rem_sh;
  logic          fits;

  assign rem_sh = {rem[ValW-1:0], acc[NumW-1]};
  assign fits   = rem_sh >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        U_IDLE: begin
          if (req.start) begin
            acc     <= '0;
            mcand   <= {{ValW{1'b0}}, req.span};
            mplier  <= req.cnt;
            dvsr    <= req.divisor;
            spn     <= req.span;
            bit_cnt <= BitCntW'(ValW - 1);
            state   <= U_MUL;
          end
        end
        // one multiplier bit per cycle
        U_MUL: begin
          if (mplier[0]) begin
            acc <= acc + {1'b0, mcand};
          end
          mcand   <= {mcand[ProdW-2:0], 1'b0};
          mplier  <= {1'b0, mplier[ValW-1:1]};
          bit_cnt <= bit_cnt - 1'b1;
          if (bit_cnt == '0) begin
            state <= U_ADD;
          end
        end
        // round up: numerator = product + divisor - 1
        U_ADD: begin
          acc     <= acc + {{(NumW-ValW){1'b0}}, dvsr} - NumW'(1);
          rem     <= '0;
          bit_cnt <= BitCntW'(NumW - 1);
          state   <= U_DIV;
        end
        // one quotient bit per cycle, shifted in where the numerator leaves
        U_DIV: begin
          rem     <= fits ? (rem_sh - {1'b0, dvsr}) : rem_sh;
          acc     <= {acc[NumW-2:0], fits};
          bit_cnt <= bit_cnt - 1'b1;
          if (bit_cnt == '0) begin
            done  <= 1'b1;
            state <= U_IDLE;
          end
        end
        default: begin
          state <= U_IDLE;
        end
      endcase
    end
  end

  // quotient clamped to span
  assign rsp.done = done;
  assign rsp.step = (acc > {{(NumW-ValW){1'b0}}, spn}) ? spn : acc[ValW-1:0];

endmodule

// File: design/bldc_startup_ramp_sequencer.sv
// Top level: debounced start/stop control and open-loop startup interval ramp.
//
//  channel  | dir | word
//  ---------+-----+-----------------------------------------------------------
//  sample   | in  | throttle[15:0], one word per tick
//  result   | out | motor_on, ramping, interval[15:0], interval_update,
//           |     | start_event, stop_event; one word per tick
//  cfg      | in  | index[2:0], data[15:0]; always ready
//
// A tick that advances a non-degenerate ramp goes from accept to result valid
// through the serial multiplier, one rounding add and the restoring divider
// (S_CALC), then S_HOLD; other ticks go straight to S_HOLD. One tick is in
// flight at a time; the next is accepted once its result sits in the output
// register, even if that word is not yet taken. Reset (rst, synchronous)
// clears config and control registers, not the result payload or ramp datapath.
module bldc_startup_ramp_sequencer import bsr_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  bsr_sample_if.sink     sample,
  bsr_result_if.source   result,
  bsr_cfg_if.sink        cfg
);

  // Configuration registers
  logic [ValW-1:0] thr_level;
  logic [ValW-1:0] debounce;
  logic [ValW-1:0] start_ivl;
  logic [ValW-1:0] end_ivl;
  logic [ValW-1:0] ramp_len;

  // Sequencer state
  seq_state_t      state;
  logic            running;
  logic            in_ramp;
  logic [ValW-1:0] on_cnt;
  logic [ValW-1:0] off_cnt;
  logic [ValW-1:0] ramp_count;
  logic [ValW-1:0] cur_ivl;
  logic            p_upd;
  logic            p_start;
  logic            p_stop;
  logic            out_valid;

  logic            running_next;
  logic            in_ramp_next;
  logic [ValW-1:0] on_cnt_next;
  logic [ValW-1:0] off_cnt_next;
  logic [ValW-1:0] ramp_count_next;
  logic [ValW-1:0] cur_ivl_next;
  logic            upd_next;
  logic            start_next;
  logic            stop_next;
  logic            need_calc;

  logic      fire;
  logic      thr_ge;
  logic      degenerate;
  logic      slot_free;
  ramp_req_t req;
  ramp_rsp_t rsp;

  assign fire       = sample.valid && sample.ready;
  assign thr_ge     = sample.throttle >= thr_level;
  assign degenerate = (ramp_len == '0) || (end_ivl > start_ivl);
  assign slot_free  = !out_valid || result.ready;

  // Register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_level <= '0;
      debounce  <= '0;
      start_ivl <= '0;
      end_ivl   <= '0;
      ramp_len  <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_THRESHOLD: thr_level <= cfg.data;
        REG_DEBOUNCE:  debounce  <= cfg.data;
        REG_START:     start_ivl <= cfg.data;
        REG_END:       end_ivl   <= cfg.data;
        REG_RAMP:      ramp_len  <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // Tick decision: debounce, start/stop and ramp counter
  always_comb begin
    running_next    = running;
    in_ramp_next    = in_ramp;
    on_cnt_next     = on_cnt;
    off_cnt_next    = off_cnt;
    ramp_count_next = ramp_count;
    cur_ivl_next    = cur_ivl;
    upd_next        = 1'b0;
    start_next      = 1'b0;
    stop_next       = 1'b0;
    need_calc       = 1'b0;
    if (running) begin
      if (!thr_ge) begin
        if (off_cnt < debounce) begin
          off_cnt_next = off_cnt + 1'b1;
        end else begin
          off_cnt_next = '0;
          running_next = 1'b0;
          in_ramp_next = 1'b0;
          stop_next    = 1'b1;
        end
      end else begin
        off_cnt_next = '0;
        if (in_ramp) begin
          if (ramp_count < ramp_len) begin
            ramp_count_next = ramp_count + 1'b1;
          end else begin
            in_ramp_next = 1'b0;
          end
          upd_next = 1'b1;
          if (degenerate) begin
            cur_ivl_next = end_ivl;
          end else begin
            need_calc = 1'b1;
          end
        end
      end
    end else begin
      if (thr_ge) begin
        if (on_cnt < debounce) begin
          on_cnt_next = on_cnt + 1'b1;
        end else begin
          on_cnt_next     = '0;
          running_next    = 1'b1;
          in_ramp_next    = 1'b1;
          ramp_count_next = '0;
          cur_ivl_next    = start_ivl;
          upd_next        = 1'b1;
          start_next      = 1'b1;
        end
      end else begin
        on_cnt_next = '0;
      end
    end
  end

  // Ramp arithmetic request; count clamped to the ramp length
  assign req.start   = fire && need_calc;
  assign req.span    = start_ivl - end_ivl;
  assign req.cnt     = (ramp_count_next > ramp_len) ? ramp_len : ramp_count_next;
  assign req.divisor = ramp_len;

  bsr_ramp_unit u_ramp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign sample.ready = (state == S_IDLE);

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      running    <= 1'b0;
      in_ramp    <= 1'b0;
      on_cnt     <= '0;
      off_cnt    <= '0;
      ramp_count <= '0;
      cur_ivl    <= '0;
      p_upd      <= 1'b0;
      p_start    <= 1'b0;
      p_stop     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // output slot: filled from S_HOLD, emptied when the word is taken
      if (state == S_HOLD && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (fire) begin
            running    <= running_next;
            in_ramp    <= in_ramp_next;
            on_cnt     <= on_cnt_next;
            off_cnt    <= off_cnt_next;
            ramp_count <= ramp_count_next;
            cur_ivl    <= cur_ivl_next;
            p_upd      <= upd_next;
            p_start    <= start_next;
            p_stop     <= stop_next;
            state      <= need_calc ? S_CALC : S_HOLD;
          end
        end
        S_CALC: begin
          if (rsp.done) begin
            cur_ivl <= start_ivl - rsp.step;
            state   <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result payload, loaded as the word moves into the output slot
  always_ff @(posedge clk) begin
    if (state == S_HOLD && slot_free) begin
      result.motor_on        <= running;
      result.ramping         <= in_ramp;
      result.interval        <= cur_ivl;
      result.interval_update <= p_upd;
      result.start_event     <= p_start;
      result.stop_event      <= p_stop;
    end
  end

  assign result.valid = out_valid;

  // Checks
  a_done_in_calc: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> state == S_CALC)
    else $error("ramp unit finished outside of a calculation");

  a_calc_running: assert property (@(posedge clk) disable iff (rst)
    state == S_CALC |-> running)
    else $error("ramp calculation while motor is off");

  a_start_word: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.start_event) |->
      (result.motor_on && result.ramping && result.interval_update && !result.stop_event))
    else $error("start word inconsistent");

  a_stop_word: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.stop_event) |->
      (!result.motor_on && !result.ramping && !result.interval_update))
    else $error("stop word inconsistent");

endmodule
